/* sv/hki_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hki_pkg: shared types and codes of the Hermite keyframe interpolator
// Holds the action and status codes, the command word passed from the front
// end to the back end, and the layout of one stored keyframe.
// ----------------------------------------------------------------------------
package hki_pkg;

  // Action codes as they arrive on the input channel.
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  // Status codes returned with every result.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    K_CLEAR,
    K_INSERT,
    K_QUERY,
    K_NOP
  } cmd_kind_e;

  typedef struct packed {
    logic signed [23:0] frame;
    logic signed [31:0] value;
    logic signed [31:0] slope;
  } key_t;

  typedef struct packed {
    cmd_kind_e kind;
    key_t      key;
  } cmd_t;

endpackage
`default_nettype wire

/* sv/hki_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hki_if: channel interfaces of the Hermite keyframe interpolator
// One interface for the command channel and one for the result channel,
// each with valid, ready and the payload.
// ----------------------------------------------------------------------------
interface hki_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [23:0] frame;
  logic signed [31:0] key_value;
  logic signed [31:0] key_slope;

  modport source (output valid, action, frame, key_value, key_slope, input ready);
  modport sink   (input valid, action, frame, key_value, key_slope, output ready);
endinterface

interface hki_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [1:0]         status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

/* sv/hki_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hki_front: command front end
// Accepts input beats, decodes the action into a command kind and holds the
// commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module hki_front (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  hki_in_if.sink         item_i,
  output hki_pkg::cmd_t  cmd_o,
  output logic           cmd_valid_o,
  input  wire logic      cmd_pop_i
);

  hki_pkg::cmd_t slot_q [2];
  hki_pkg::cmd_t cmd_in;
  logic          wptr_q, rptr_q;
  logic [1:0]    fill_q;
  logic          push, pop;

  always_comb begin
    unique case (item_i.action)
      hki_pkg::ACT_CLEAR:  cmd_in.kind = hki_pkg::K_CLEAR;
      hki_pkg::ACT_INSERT: cmd_in.kind = hki_pkg::K_INSERT;
      hki_pkg::ACT_QUERY:  cmd_in.kind = hki_pkg::K_QUERY;
      default:             cmd_in.kind = hki_pkg::K_NOP;
    endcase
    cmd_in.key.frame = item_i.frame;
    cmd_in.key.value = item_i.key_value;
    cmd_in.key.slope = item_i.key_slope;
  end

  assign item_i.ready = (fill_q != 2'd2);
  assign push         = item_i.valid && item_i.ready;
  assign cmd_valid_o  = (fill_q != 2'd0);
  assign pop          = cmd_pop_i && cmd_valid_o;
  assign cmd_o        = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wptr_q] <= cmd_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      fill_q <= fill_q + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

/* sv/hki_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hki_back: command execution back end
// Owns the sorted key memory, performs inserts by shifting keys up, searches
// for the bracketing keys on a query, divides for t and evaluates the Hermite
// blend on a shared multiplier. Drives the registered result channel.
// ----------------------------------------------------------------------------
module hki_back #(
  parameter int MAX_KEYS = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire hki_pkg::cmd_t  cmd_i,
  input  wire logic           cmd_valid_i,
  output logic                cmd_pop_o,
  hki_out_if.source           result_o
);

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_CMP = 4'd2;
  localparam logic [3:0] S_INS_WR0 = 4'd3;
  localparam logic [3:0] S_QRY_RD  = 4'd4;
  localparam logic [3:0] S_QRY_CMP = 4'd5;
  localparam logic [3:0] S_SETUP   = 4'd6;
  localparam logic [3:0] S_DIV     = 4'd7;
  localparam logic [3:0] S_MUL     = 4'd8;
  localparam logic [3:0] S_RND     = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  localparam logic signed [67:0] R_MAX = 68'sd2147483647;
  localparam logic signed [67:0] R_MIN = -68'sd2147483648;

  hki_pkg::key_t mem [MAX_KEYS];
  hki_pkg::key_t rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  hki_pkg::key_t mem_wdata;

  logic [3:0]    state_q, state_d;
  hki_pkg::cmd_t cmd_q, cmd_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q, idx_d;
  hki_pkg::key_t prev_q, prev_d, pv_q, pv_d, nx_q, nx_d;
  logic [23:0]   gap_q, gap_d;
  logic [24:0]   rem_q, rem_d;
  logic [16:0]   t_q, t_d, t2_q, t2_d;
  logic [4:0]    div_cnt_q, div_cnt_d;
  logic [2:0]    k_q, k_d;
  logic signed [19:0] h10_q, h10_d, h11_q, h11_d, h00_q, h00_d, h01_q, h01_d;
  logic signed [47:0] sp_q, sp_d, sn_q, sn_d;
  logic signed [67:0] acc_q, acc_d;
  logic signed [31:0] res_q, res_d;
  logic [1:0]         sts_q, sts_d;
  logic               out_vld_q, out_vld_d;
  logic signed [31:0] out_res_q, out_res_d;
  logic [1:0]         out_sts_q, out_sts_d;

  logic signed [47:0] mh_a;
  logic signed [19:0] mh_b;
  logic signed [67:0] mh_p_q;
  logic signed [31:0] ms_a;
  logic signed [56:0] ms_p_q;

  logic signed [24:0] gap_w, diff_w;
  logic signed [23:0] qc;
  logic               div_ge;
  logic [24:0]        div_sub;
  logic [16:0]        t_hi;
  logic signed [19:0] t_s, t2_s, t3_s;
  logic signed [67:0] rnd;
  logic               last_key;

  assign result_o.valid        = out_vld_q;
  assign result_o.result_value = out_res_q;
  assign result_o.status       = out_sts_q;

  // Key memory: one write and one registered read a cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_q <= mem[idx_q];
  end

  // Shared multipliers, each registered.
  always_ff @(posedge clk_i) begin
    mh_p_q <= mh_a * mh_b;
    ms_p_q <= ms_a * $signed({1'b0, gap_q});
  end

  assign t_hi = mh_p_q[32:16];
  assign t_s  = $signed(20'(t_q));
  assign t2_s = $signed(20'(t2_q));
  assign t3_s = $signed(20'(t_hi));

  always_comb begin
    mh_a = '0;
    mh_b = '0;
    unique case (k_q)
      3'd0: begin mh_a = 48'(t_q);  mh_b = t_s;   end
      3'd1: begin mh_a = 48'(t_hi); mh_b = t_s;   end
      3'd3: begin mh_a = sp_q;      mh_b = h10_q; end
      3'd4: begin mh_a = sn_q;      mh_b = h11_q; end
      3'd5: begin mh_a = 48'(pv_q.value); mh_b = h00_q; end
      3'd6: begin mh_a = 48'(nx_q.value); mh_b = h01_q; end
      default: begin mh_a = '0; mh_b = '0; end
    endcase
    ms_a = (k_q == 3'd0) ? pv_q.slope : nx_q.slope;
  end

  assign gap_w    = 25'(nx_q.frame) - 25'(pv_q.frame);
  assign div_ge   = rem_q >= {1'b0, gap_q};
  assign div_sub  = div_ge ? (rem_q - {1'b0, gap_q}) : rem_q;
  assign rnd      = (acc_q + 68'sd32768) >>> 16;
  assign last_key = (CW'(idx_q) == count_q - CW'(1));

  always_comb begin
    priority if (cmd_q.key.frame < pv_q.frame) qc = pv_q.frame;
    else if (cmd_q.key.frame > nx_q.frame)      qc = nx_q.frame;
    else                                        qc = cmd_q.key.frame;
    diff_w = 25'(qc) - 25'(pv_q.frame);
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    count_d   = count_q;
    idx_d     = idx_q;
    prev_d    = prev_q;
    pv_d      = pv_q;
    nx_d      = nx_q;
    gap_d     = gap_q;
    rem_d     = rem_q;
    t_d       = t_q;
    t2_d      = t2_q;
    div_cnt_d = div_cnt_q;
    k_d       = k_q;
    h10_d     = h10_q;
    h11_d     = h11_q;
    h00_d     = h00_q;
    h01_d     = h01_q;
    sp_d      = sp_q;
    sn_d      = sn_q;
    acc_d     = acc_q;
    res_d     = res_q;
    sts_d     = sts_q;
    out_vld_d = out_vld_q && !result_o.ready;
    out_res_d = out_res_q;
    out_sts_d = out_sts_q;
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx_q + AW'(1);
    mem_wdata = rd_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          res_d     = '0;
          sts_d     = hki_pkg::ST_OK;
          state_d   = S_FIN;
          unique case (cmd_i.kind)
            hki_pkg::K_CLEAR: count_d = '0;
            hki_pkg::K_INSERT: begin
              if (count_q == CW'(MAX_KEYS)) begin
                sts_d = hki_pkg::ST_FULL;
              end else begin
                count_d = count_q + CW'(1);
                if (count_q == '0) begin
                  mem_we    = 1'b1;
                  mem_waddr = '0;
                  mem_wdata = cmd_i.key;
                end else begin
                  idx_d   = AW'(count_q - CW'(1));
                  state_d = S_INS_RD;
                end
              end
            end
            hki_pkg::K_QUERY: begin
              if (count_q == '0) begin
                sts_d = hki_pkg::ST_EMPTY;
              end else begin
                idx_d   = '0;
                state_d = S_QRY_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS_RD: state_d = S_INS_CMP;
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (rd_q.frame > cmd_q.key.frame) begin
          if (idx_q == '0) begin
            state_d = S_INS_WR0;
          end else begin
            idx_d   = idx_q - AW'(1);
            state_d = S_INS_RD;
          end
        end else begin
          mem_wdata = cmd_q.key;
          state_d   = S_FIN;
        end
      end
      S_INS_WR0: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = cmd_q.key;
        state_d   = S_FIN;
      end
      S_QRY_RD: state_d = S_QRY_CMP;
      S_QRY_CMP: begin
        if (rd_q.frame >= cmd_q.key.frame || last_key) begin
          nx_d    = rd_q;
          pv_d    = (cmd_q.key.frame < rd_q.frame && idx_q != '0) ? prev_q : rd_q;
          state_d = S_SETUP;
        end else begin
          prev_d  = rd_q;
          idx_d   = idx_q + AW'(1);
          state_d = S_QRY_RD;
        end
      end
      S_SETUP: begin
        if (gap_w < 25'sd3) begin
          res_d   = pv_q.value;
          state_d = S_FIN;
        end else begin
          gap_d     = gap_w[23:0];
          rem_d     = diff_w;
          t_d       = '0;
          div_cnt_d = '0;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        t_d       = {t_q[15:0], div_ge};
        rem_d     = {div_sub[23:0], 1'b0};
        div_cnt_d = div_cnt_q + 5'd1;
        if (div_cnt_q == 5'd16) begin
          k_d     = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        k_d = k_q + 3'd1;
        unique case (k_q)
          3'd1: begin
            t2_d = t_hi;
            sp_d = ms_p_q[55:8];
          end
          3'd2: begin
            h10_d = t3_s - (t2_s <<< 1) + t_s;
            h11_d = t3_s - t2_s;
            h00_d = 20'sd65536 + (t3_s <<< 1) - 20'(3 * t2_s);
            h01_d = 20'(3 * t2_s) - (t3_s <<< 1);
            sn_d  = ms_p_q[55:8];
          end
          3'd4: acc_d = mh_p_q;
          3'd5, 3'd6: acc_d = acc_q + mh_p_q;
          3'd7: begin
            acc_d   = acc_q + mh_p_q;
            state_d = S_RND;
          end
          default: ;
        endcase
      end
      S_RND: begin
        priority if (rnd > R_MAX) res_d = R_MAX[31:0];
        else if (rnd < R_MIN)     res_d = R_MIN[31:0];
        else                      res_d = rnd[31:0];
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_vld_q || result_o.ready) begin
          out_vld_d = 1'b1;
          out_res_d = res_q;
          out_sts_d = sts_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    idx_q     <= idx_d;
    prev_q    <= prev_d;
    pv_q      <= pv_d;
    nx_q      <= nx_d;
    gap_q     <= gap_d;
    rem_q     <= rem_d;
    t_q       <= t_d;
    t2_q      <= t2_d;
    div_cnt_q <= div_cnt_d;
    k_q       <= k_d;
    h10_q     <= h10_d;
    h11_q     <= h11_d;
    h00_q     <= h00_d;
    h01_q     <= h01_d;
    sp_q      <= sp_d;
    sn_q      <= sn_d;
    acc_q     <= acc_d;
    res_q     <= res_d;
    sts_q     <= sts_d;
    out_res_q <= out_res_d;
    out_sts_q <= out_sts_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule
`default_nettype wire

/* sv/hermite_keyframe_interpolator.sv */
`default_nettype none
// Work per beat: a clear, a dropped insert, a query on an empty table or an
// unused action goes straight to the result register. An insert reads and
// compares every stored key that has a later frame than the new one, since
// the keys are moved up one place at a time through the single read and single
// write port of the key memory. A query reads and compares every key scanned
// up to and including the bracketing key, then, unless the keys are closer
// than 0.01 frame, runs the bit-serial division that forms t and the Hermite
// blend on the shared multiplier, then rounding and the result register. A
// two-entry command queue lets new beats be taken while the back end works or
// while a result waits to be collected.
// ----------------------------------------------------------------------------
// hermite_keyframe_interpolator: sorted keyframe table with cubic Hermite query
// Keeps up to MAX_KEYS keyframes (Q16.8 frame, Q16.16 value and slope) sorted
// by frame and returns saturated Q16.16 interpolated values on query.
// ----------------------------------------------------------------------------
// Each input beat produces exactly one result beat. A clear empties the table.
// An insert places the key after all keys of equal frame, or reports a full
// table. A query brackets the frame with two keys, returns the earlier value
// when they are closer than 0.01 frame, and otherwise evaluates the cubic
// Hermite blend with slopes scaled by the frame gap, rounded half up.
module hermite_keyframe_interpolator #(
  parameter int MAX_KEYS = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hki_in_if.sink    item_i,
  hki_out_if.source result_o
);

  // Decoded commands waiting for the back end.
  hki_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_pop;

  hki_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  // The back end owns the key table and the arithmetic, and registers every
  // result beat; the front end queue keeps accepting beats meanwhile until full.
  hki_back #(
    .MAX_KEYS (MAX_KEYS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .result_o    (result_o)
  );

endmodule
`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench of the Hermite keyframe interpolator
// Drives clear, insert, query and unused beats, directed first and then random
// sequences with random idling and one long output stall. Each result beat is
// checked against a keyframe table kept in the bench.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int         TABLE_DEPTH = 64;
  localparam int         ITEM_TARGET = 1650;

  // One expected result beat.
  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         status;
  } outcome_t;

  // Keeps its own sorted keyframe table, computes the outcome of every
  // accepted command beat and compares result beats against them in order.
  class keyframe_tracker;
    logic signed [23:0] frames[TABLE_DEPTH];
    logic signed [31:0] values[TABLE_DEPTH];
    logic signed [31:0] slopes[TABLE_DEPTH];
    int                 count;
    outcome_t           pending[$];
    int                 failures;
    int                 n_insert, n_dropped, n_empty, n_blend, n_near;

    function new();
      count = 0;
      failures = 0;
    endfunction

    // Cubic Hermite blend between the two keys that bracket the frame.
    function logic signed [31:0] hermite_at(logic signed [23:0] q);
      int     nx, pv;
      longint gap, t, t2, t3, h10, h11, h00, h01, sp, sn, sum, r, qc;
      nx = 0;
      while (nx < count && frames[nx] < q) nx++;
      if (nx == count) nx = count - 1;
      pv = nx;
      if (q < frames[pv] && pv != 0) pv--;
      gap = longint'(frames[nx]) - longint'(frames[pv]);
      // Keys closer than a hundredth of a frame: the earlier value stands.
      if (gap < 3) begin
        n_near++;
        return values[pv];
      end
      n_blend++;
      qc = q;
      if (qc < frames[pv]) qc = frames[pv];
      if (qc > frames[nx]) qc = frames[nx];
      t   = ((qc - longint'(frames[pv])) * 65536) / gap;
      t2  = (t * t) / 65536;
      t3  = (t2 * t) / 65536;
      h10 = t3 - 2 * t2 + t;
      h11 = t3 - t2;
      h00 = 65536 + 2 * t3 - 3 * t2;
      h01 = 3 * t2 - 2 * t3;
      sp  = (longint'(slopes[pv]) * gap) >>> 8;
      sn  = (longint'(slopes[nx]) * gap) >>> 8;
      sum = sp * h10 + sn * h11 + longint'(values[pv]) * h00 + longint'(values[nx]) * h01;
      r   = (sum + 32768) >>> 16;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
    endfunction

    function void note_command(logic [1:0] act, logic signed [23:0] frame,
                               logic signed [31:0] kv, logic signed [31:0] ks);
      outcome_t o;
      int       pos;
      o.value  = '0;
      o.status = hki_pkg::ST_OK;
      case (act)
        hki_pkg::ACT_CLEAR: count = 0;
        hki_pkg::ACT_INSERT: begin
          if (count >= TABLE_DEPTH) begin
            o.status = hki_pkg::ST_FULL;
            n_dropped++;
          end else begin
            pos = 0;
            while (pos < count && frames[pos] <= frame) pos++;
            for (int i = count; i > pos; i--) begin
              frames[i] = frames[i-1];
              values[i] = values[i-1];
              slopes[i] = slopes[i-1];
            end
            frames[pos] = frame;
            values[pos] = kv;
            slopes[pos] = ks;
            count++;
            n_insert++;
          end
        end
        hki_pkg::ACT_QUERY: begin
          if (count == 0) begin
            o.status = hki_pkg::ST_EMPTY;
            n_empty++;
          end else begin
            o.value = hermite_at(frame);
          end
        end
        default: ;
      endcase
      pending.push_back(o);
    endfunction

    function void check_result(logic signed [31:0] value, logic [1:0] status);
      outcome_t o;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: value %0d status %0d", value, status);
        failures++;
        return;
      end
      o = pending.pop_front();
      if (value !== o.value) begin
        $error("result_value: expected %0d, got %0d", o.value, value);
        failures++;
      end
      if (status !== o.status) begin
        $error("status: expected %0d, got %0d", o.status, status);
        failures++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  hki_in_if  cmd_ch ();
  hki_out_if res_ch ();

  hermite_keyframe_interpolator dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (cmd_ch.sink),
    .result_o (res_ch.source)
  );

  keyframe_tracker tracker;

  // Idle percentages of the two sides; changed by the stimulus as it goes.
  int  send_idle_pct;
  int  recv_idle_pct;
  // Set while the output is deliberately held off for a long stretch.
  bit  hold_output;
  int  beats_sent;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The run must never take longer than this; well above the slowest run.
  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Offers one command beat and waits until the block takes it. The valid is
  // only lowered when an idle gap is due, so back-to-back beats keep it high.
  task automatic send_command(logic [1:0] act, logic signed [23:0] frame,
                              logic signed [31:0] kv, logic signed [31:0] ks);
    if ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.action    <= act;
    cmd_ch.frame     <= frame;
    cmd_ch.key_value <= kv;
    cmd_ch.key_slope <= ks;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    tracker.note_command(act, frame, kv, ks);
    beats_sent++;
  endtask

  // Picks a frame near the base. Narrow spreads give near-equal keys and
  // duplicates, wide ones give large gaps and reach every bit of the field.
  function automatic logic signed [23:0] pick_frame(int base, int spread_kind);
    case (spread_kind)
      0:       return 24'(base + int'($urandom_range(6)) - 3);
      1:       return 24'(base + int'($urandom_range(4096)) - 2048);
      default: return 24'($urandom);
    endcase
  endfunction

  // Values and slopes are usually moderate so the blend stays in range, and
  // now and then fully random to reach saturation and the sign bits.
  function automatic logic signed [31:0] pick_word();
    if ($urandom_range(3) == 0) return $urandom;
    return 32'(int'($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
  endfunction

  // Sampling and the ready of the result channel share one process, so a
  // beat is judged on the values that stood at the clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) tracker.check_result(res_ch.result_value, res_ch.status);
      res_ch.ready <= !hold_output && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long output stall, timed in cycles: the block fills its command queue
  // and has to refuse further beats until the stall ends.
  initial begin
    hold_output = 1'b0;
    wait (beats_sent >= 200);
    @(posedge clk_i);
    hold_output = 1'b1;
    repeat (3000) @(posedge clk_i);
    hold_output = 1'b0;
  end

  initial begin
    int base, spread_kind, n_keys, n_queries, settle;
    tracker = new();
    beats_sent       = 0;
    send_idle_pct    = 32;
    recv_idle_pct    = 68;
    rst_ni           = 1'b0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.action    = hki_pkg::ACT_CLEAR;
    cmd_ch.frame     = '0;
    cmd_ch.key_value = '0;
    cmd_ch.key_slope = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty table, the unused action, duplicate and near-equal
    // frames, queries before the first and past the last key, field extremes.
    send_command(hki_pkg::ACT_QUERY, 24'sd0, '0, '0);
    send_command(ACT_UNUSED, 24'sd256, 32'sh7fff_ffff, 32'sh8000_0000);
    send_command(hki_pkg::ACT_INSERT, 24'sd256, 32'sh0001_0000, 32'sh0000_8000);
    send_command(hki_pkg::ACT_INSERT, 24'sd2560, -32'sh0003_0000, 32'sh0002_0000);
    send_command(hki_pkg::ACT_INSERT, 24'sd256, 32'sh0005_0000, -32'sh0001_0000);
    send_command(hki_pkg::ACT_INSERT, 24'sd258, 32'sh0007_0000, 32'sh0000_0000);
    send_command(hki_pkg::ACT_INSERT, 24'sd2563, 32'sh0002_0000, 32'sh0001_0000);
    send_command(hki_pkg::ACT_QUERY, -24'sd8388608, '0, '0);
    send_command(hki_pkg::ACT_QUERY, 24'sd8388607, '0, '0);
    send_command(hki_pkg::ACT_QUERY, 24'sd256, '0, '0);
    send_command(hki_pkg::ACT_QUERY, 24'sd257, '0, '0);
    send_command(hki_pkg::ACT_QUERY, 24'sd1000, '0, '0);
    send_command(hki_pkg::ACT_QUERY, 24'sd2561, '0, '0);
    send_command(hki_pkg::ACT_INSERT, 24'sd8388607, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_command(hki_pkg::ACT_INSERT, -24'sd8388608, 32'sh8000_0000, 32'sh8000_0000);
    send_command(hki_pkg::ACT_QUERY, 24'sd4000000, '0, '0);
    send_command(hki_pkg::ACT_QUERY, -24'sd4000000, '0, '0);
    send_command(hki_pkg::ACT_QUERY, -24'sd1, '0, '0);
    send_command(ACT_UNUSED, -24'sd1, 32'shffff_ffff, 32'shffff_ffff);
    send_command(hki_pkg::ACT_CLEAR, 24'sd8388607, 32'shffff_ffff, 32'shffff_ffff);
    send_command(hki_pkg::ACT_QUERY, 24'sd100, '0, '0);

    // Random part: mostly a clear, a batch of keys and a batch of queries
    // around them; sometimes enough keys to overflow the table; the rest is
    // noise with any action and any field value.
    while (beats_sent < ITEM_TARGET) begin
      if (beats_sent >= 2 * ITEM_TARGET / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (beats_sent >= ITEM_TARGET / 3) begin
        send_idle_pct = 68;
        recv_idle_pct = 32;
      end
      if ($urandom_range(99) < 85) begin
        base        = int'($urandom_range(200000)) - 100000;
        spread_kind = $urandom_range(2);
        n_keys      = ($urandom_range(9) == 0) ? $urandom_range(60, 70)
                                               : $urandom_range(1, 12);
        n_queries   = $urandom_range(1, 15);
        if ($urandom_range(3) != 0)
          send_command(hki_pkg::ACT_CLEAR, 24'($urandom), $urandom, $urandom);
        for (int k = 0; k < n_keys; k++)
          send_command(hki_pkg::ACT_INSERT, pick_frame(base, spread_kind), pick_word(),
                       pick_word());
        for (int k = 0; k < n_queries; k++)
          send_command(hki_pkg::ACT_QUERY, pick_frame(base, spread_kind), $urandom, $urandom);
      end else begin
        send_command(2'($urandom_range(3)), 24'($urandom), $urandom, $urandom);
      end
    end
    cmd_ch.valid <= 1'b0;

    // Drain every outstanding result, then allow a settling margin for a
    // stray beat to show up.
    settle = 0;
    while (tracker.pending.size() != 0 && settle < 200000) begin
      @(posedge clk_i);
      settle++;
    end
    repeat (400) @(posedge clk_i);

    $display("Covered %0d command beats: %0d keys stored, %0d inserts dropped on a full table.",
             beats_sent, tracker.n_insert, tracker.n_dropped);
    $display("Queries: %0d on an empty table, %0d near-equal keys, %0d blended.",
             tracker.n_empty, tracker.n_near, tracker.n_blend);
    if (tracker.failures == 0 && tracker.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (tracker.pending.size() != 0)
        $error("%0d expected results never arrived", tracker.pending.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/hki_pkg.sv
sv/hki_if.sv
sv/hki_front.sv
sv/hki_back.sv
sv/hermite_keyframe_interpolator.sv
sim/tb.sv
